FILE: rtl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mixer checker.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define SMV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Next-cycle implication, reset-qualified.
`define SMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: rtl/smv_pkg.sv
// ------------------------------------------------------------------------
// smv_pkg
// Item types, op codes and controller/datapath interface for the mixer.
// ------------------------------------------------------------------------
package smv_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_TRIG = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam int LEN_W       = 14;
	localparam int LENGTH_REGS = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int ACT_W       = 6;
	localparam int SAMPLE_W    = 16;
	localparam int PWM_W       = 12;
	localparam int MIX_MAX     = 32767;
	localparam int MIX_MIN     = -32768;

	typedef struct packed {
		logic [1:0]               op;
		logic [2:0]               voice;
		logic [12:0]              sample_addr;
		logic signed [SAMPLE_W-1:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mix_value;
		logic [PWM_W-1:0]         pwm_level;
		logic                     clipped;
		logic [ACT_W-1:0]         active_voices;
	} rsp_item_t;

	typedef struct packed {
		logic load;
		logic trig;
		logic clr;
		logic issue;
		logic sat;
		logic mul;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

FILE: rtl/smv_ram.sv
// ------------------------------------------------------------------------
// smv_ram
// Generic one-write, one-read RAM with registered read data.
// ------------------------------------------------------------------------
module smv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/smv_ctrl.sv
// ------------------------------------------------------------------------
// smv_ctrl
// Sequencer: takes items, walks the voices on a tick, orders the finish.
// ------------------------------------------------------------------------
module smv_ctrl #(
	parameter int VOICES = 6
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         req_valid,
	input  logic [1:0]                                   op,
	input  smv_pkg::dp_sts_t                             sts,
	output logic                                         req_ready,
	output smv_pkg::dp_cmd_t                             cmd,
	output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] cnt
);
	import smv_pkg::*;

	localparam int CW = (VOICES > 1) ? $clog2(VOICES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_SAT,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign cnt       = cnt_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept && (op == OP_LOAD);
		cmd.trig     = accept && (op == OP_TRIG);
		cmd.clr      = accept && (op == OP_TICK);
		cmd.issue    = (state_q == ST_SCAN);
		cmd.sat      = (state_q == ST_SAT);
		cmd.mul      = (state_q == ST_MUL);
		cmd.out_load = (state_q == ST_OUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && (op == OP_TICK)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CW'(VOICES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_SAT;
				ST_SAT:   state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_OUT;
				ST_OUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/smv_dp.sv
// ------------------------------------------------------------------------
// smv_dp
// Mixer datapath: sample store, voice counters, accumulator, scaler, output.
// ------------------------------------------------------------------------
module smv_dp #(
	parameter int VOICES       = 6,
	parameter int SAMPLE_DEPTH = 8192,
	parameter int PWM_TOP      = 4095
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  smv_pkg::in_item_t                            req,
	input  smv_pkg::dp_cmd_t                             cmd,
	input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] cnt,
	input  logic                                         cfg_we,
	input  logic [smv_pkg::CFG_IDX_W-1:0]                cfg_index,
	input  logic [smv_pkg::LEN_W-1:0]                    cfg_data,
	input  logic                                         rsp_ready,
	output smv_pkg::dp_sts_t                             sts,
	output logic                                         rsp_valid,
	output smv_pkg::rsp_item_t                           rsp
);
	import smv_pkg::*;

	localparam int MEM_DEPTH = VOICES * SAMPLE_DEPTH;
	localparam int MW        = $clog2(MEM_DEPTH);
	localparam int SW        = SAMPLE_W + $clog2(VOICES + 1);
	localparam int PADL      = (VOICES > LENGTH_REGS) ? VOICES : LENGTH_REGS;
	localparam int PADW      = (VOICES > ACT_W) ? VOICES : ACT_W;
	localparam logic signed [SW-1:0] SUM_MAX = SW'(MIX_MAX);
	localparam logic signed [SW-1:0] SUM_MIN = SW'(MIX_MIN);

	logic [LEN_W-1:0]        len_q [PADL];
	logic [LEN_W-1:0]        vlen  [VOICES];
	logic [LEN_W-1:0]        rem_q [VOICES];
	logic [VOICES-1:0]       mask_q;
	logic [LEN_W-1:0]        cur_len;
	logic [LEN_W-1:0]        cur_rem;
	logic [LEN_W-1:0]        pos;
	logic                    pos_ok;
	logic [MW-1:0]           rd_addr;
	logic [MW-1:0]           wr_addr;
	logic                    wr_en;
	logic [SAMPLE_W-1:0]     rd_data;
	logic                    hit_s1;
	logic signed [SW-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] mix_q;
	logic                    clip_q;
	logic [31:0]             prod_q;
	logic [PADW-1:0]         act_pad;
	logic                    rsp_valid_q;
	rsp_item_t               rsp_q;

	// Per-voice lengths; voices without a register read as zero.
	always_comb begin
		for (int i = 0; i < VOICES; i++) begin
			vlen[i] = len_q[i];
		end
	end

	assign cur_len = vlen[cnt];
	assign cur_rem = rem_q[cnt];
	assign pos     = cur_len - cur_rem;
	assign pos_ok  = (cur_rem != '0) && (cur_rem <= cur_len) && (32'(pos) < SAMPLE_DEPTH);
	assign rd_addr = MW'(cnt) * MW'(SAMPLE_DEPTH) + MW'(pos);

	assign wr_en   = cmd.load && (32'(req.voice) < VOICES)
	                 && (32'(req.sample_addr) < SAMPLE_DEPTH);
	assign wr_addr = MW'(req.voice) * MW'(SAMPLE_DEPTH) + MW'(req.sample_addr);

	smv_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (req.sample_value),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Length registers, voice counters and playing mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PADL; i++) begin
				len_q[i] <= '0;
			end
			for (int i = 0; i < VOICES; i++) begin
				rem_q[i] <= '0;
			end
			mask_q      <= '0;
			hit_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < LENGTH_REGS; i++) begin
				if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
					len_q[i] <= cfg_data;
				end
			end
			for (int i = 0; i < VOICES; i++) begin
				if (cmd.trig && (32'(req.voice) == i)) begin
					rem_q[i]  <= vlen[i];
					mask_q[i] <= 1'b1;
				end else if (cmd.issue && (32'(cnt) == i) && mask_q[i]) begin
					if (pos_ok) begin
						rem_q[i] <= cur_rem - 1'b1;
						if (cur_rem == LEN_W'(1)) begin
							mask_q[i] <= 1'b0;
						end
					end else begin
						mask_q[i] <= 1'b0;
					end
				end
			end
			hit_s1 <= cmd.issue && mask_q[cnt] && pos_ok;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign act_pad = PADW'(mask_q);

	// Accumulate, saturate, scale, present.
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			sum_q <= '0;
		end else if (hit_s1) begin
			sum_q <= sum_q + {{(SW - SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
		end
		if (cmd.sat) begin
			if (sum_q > SUM_MAX) begin
				mix_q  <= SAMPLE_W'(MIX_MAX);
				clip_q <= 1'b1;
			end else if (sum_q < SUM_MIN) begin
				mix_q  <= SAMPLE_W'(MIX_MIN);
				clip_q <= 1'b1;
			end else begin
				mix_q  <= sum_q[SAMPLE_W-1:0];
				clip_q <= 1'b0;
			end
		end
		if (cmd.mul) begin
			prod_q <= 32'({~mix_q[SAMPLE_W-1], mix_q[SAMPLE_W-2:0]}) * 32'(PWM_TOP);
		end
		if (cmd.out_load) begin
			rsp_q.mix_value     <= mix_q;
			rsp_q.pwm_level     <= prod_q[16 +: PWM_W];
			rsp_q.clipped       <= clip_q;
			rsp_q.active_voices <= act_pad[ACT_W-1:0];
		end
	end

	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule

FILE: rtl/sample_voice_mixer_core.sv
// Load and trigger items leave the sequencer idle: next item the following cycle.
// Tick item: one sample-store read per voice on the single read port, then
// drain, saturate, scale and output; the result is registered, and the next
// item is accepted only once the result has been loaded into a free result slot.
// Reset clears lengths, voice counters, playing mask and the result slot;
// the sample store is not cleared and holds garbage until loaded.
// ------------------------------------------------------------------------
// sample_voice_mixer_core
// One-shot multi-voice sample player with saturating mix and PWM scaling.
// ------------------------------------------------------------------------
module sample_voice_mixer_core #(
	parameter int VOICES       = 6,
	parameter int SAMPLE_DEPTH = 8192,
	parameter int PWM_TOP      = 4095
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel: load, trigger or tick items
	input  logic                          req_valid,
	output logic                          req_ready,
	input  smv_pkg::in_item_t             req,
	// result channel: one item per tick
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output smv_pkg::rsp_item_t            rsp,
	// length register writes
	input  logic                          cfg_we,
	input  logic [smv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smv_pkg::LEN_W-1:0]     cfg_data
);
	import smv_pkg::*;

	localparam int CW = (VOICES > 1) ? $clog2(VOICES) : 1;

	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic [CW-1:0] cnt;

	// Sequencer: owns the handshake on the request side and the voice walk.
	smv_ctrl #(
		.VOICES (VOICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.op        (req.op),
		.sts       (sts),
		.req_ready (req_ready),
		.cmd       (cmd),
		.cnt       (cnt)
	);

	// Datapath: store writes on load, counter reload on trigger, and on a
	// tick one read per voice with the counter update done at read issue;
	// the sum adds each read in the cycle after its issue, then saturate and scale.
	smv_dp #(
		.VOICES       (VOICES),
		.SAMPLE_DEPTH (SAMPLE_DEPTH),
		.PWM_TOP      (PWM_TOP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cnt       (cnt),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/smv_chk.sv
// ------------------------------------------------------------------------
// smv_chk
// Port-level checks for the mixer, bound to the top level.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module smv_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input smv_pkg::in_item_t  req,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input smv_pkg::rsp_item_t rsp
);
	import smv_pkg::*;

	// A tick keeps the block busy for the next cycle at least.
	`SMV_ASSERT_NEXT(a_tick_busy, clk, arst_n, req_valid && req_ready && req.op == OP_TICK, !req_ready)

	// Clipping only ever reports a rail value.
	`SMV_ASSERT_IMPLY(a_clip_rail, clk, arst_n, rsp_valid && rsp.clipped, rsp.mix_value == 16'sh7fff || rsp.mix_value == 16'sh8000)

	// Load, trigger and unused items never produce a result.
	`SMV_ASSERT_NEXT(a_no_spurious, clk, arst_n, req_valid && req_ready && req.op != OP_TICK && !rsp_valid, !rsp_valid)

	// A stalled result stays offered.
	`SMV_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind sample_voice_mixer_core smv_chk u_smv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
